// ===== src/tfre_pkg.sv =====
// ----------------------------------------------------------------------------
// tfre_pkg
// Shared types and constants for the text frame rectangle engine.
// ----------------------------------------------------------------------------
package tfre_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 64;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = $clog2(CELLS);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	localparam logic [2:0] MODE_CLEAR        = 3'd0;
	localparam logic [2:0] MODE_OUTLINE      = 3'd1;
	localparam logic [2:0] MODE_FILL         = 3'd2;
	localparam logic [2:0] MODE_FILL_OUTLINE = 3'd3;
	localparam logic [2:0] MODE_READ         = 3'd4;

	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

	localparam logic [7:0] FRAME_WIDTH_RST  = 8'd80;
	localparam logic [6:0] FRAME_HEIGHT_RST = 7'd25;

	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_REJECTED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_READ,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [7:0]    wdata;
	} mem_req_t;

endpackage

// ===== src/tfre_frame_mem.sv =====
// ----------------------------------------------------------------------------
// tfre_frame_mem
// Single-port cell store with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module tfre_frame_mem (
	input  logic              clk,
	input  tfre_pkg::mem_req_t req,
	output logic [7:0]        rd_data
);
	import tfre_pkg::*;

	logic [7:0] cells [CELLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			cells[req.addr] <= req.wdata;
		end
		rd_data <= cells[req.addr];
	end

endmodule

// ===== src/text_frame_rect_engine.sv =====
// ----------------------------------------------------------------------------
// text_frame_rect_engine
// Byte-per-cell text frame with clear, outline, fill, fill-with-outline and cell read commands.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  command   start, busy            mode, x, y, rect_width, rect_height,
//                                   draw_byte, fill_byte
//  result    done (one cycle)       status, read_byte
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
//  Rectangles and clears are paced by the single write port of the cell
//  store, which takes one cell per cycle. A read passes through the
//  ST_READ and ST_RESP states before its result. Reset leaves the cell
//  contents undefined. The result cannot be held off; a new command is
//  taken in its cycle.
// ----------------------------------------------------------------------------
module text_frame_rect_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] mode,
	input  logic [6:0] x,
	input  logic [5:0] y,
	input  logic [7:0] rect_width,
	input  logic [6:0] rect_height,
	input  logic [7:0] draw_byte,
	input  logic [7:0] fill_byte,
	output logic       done,
	output logic       status,
	output logic [7:0] read_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import tfre_pkg::*;

	state_t state_q, state_d;

	logic [7:0] frame_width_q;
	logic [6:0] frame_height_q;
	logic [7:0] fw_eff;
	logic [6:0] fh_eff;

	logic [2:0]       op_q;
	logic [AW-1:0]    row_base_q;
	logic [COL_W-1:0] col_q, wm1_q;
	logic [ROW_W-1:0] row_q, hm1_q;
	logic [7:0]       draw_q, fill_q;

	logic done_q, status_q;
	logic [7:0] read_byte_q;

	logic load_clear, load_rect, load_read;
	logic finish, finish_read, fin_status;
	logic frame_empty, rect_bad, read_bad;
	logic last_cell, border;
	logic [AW-1:0] start_addr;
	logic [AW-1:0] mult_full;
	logic [7:0] rd_data;
	mem_req_t mem_req;

	assign fw_eff = (frame_width_q > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : frame_width_q;
	assign fh_eff = (frame_height_q > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : frame_height_q;

	assign frame_empty = (fw_eff == 8'd0) || (fh_eff == 7'd0);
	assign rect_bad = (rect_width == 8'd0) || (rect_height == 7'd0)
		|| (({2'b00, x} + {1'b0, rect_width}) > {1'b0, fw_eff})
		|| (({2'b00, y} + {1'b0, rect_height}) > {1'b0, fh_eff});
	assign read_bad = ({1'b0, x} >= fw_eff) || ({1'b0, y} >= fh_eff);

	assign mult_full  = AW'(y) * AW'(fw_eff) + AW'(x);
	assign start_addr = mult_full;

	assign last_cell = (row_q == hm1_q) && (col_q == wm1_q);
	assign border = (row_q == '0) || (row_q == hm1_q) || (col_q == '0) || (col_q == wm1_q);

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign status    = status_q;
	assign read_byte = read_byte_q;

	always_comb begin
		mem_req.addr  = row_base_q + AW'(col_q);
		mem_req.we    = 1'b0;
		mem_req.wdata = draw_q;
		if (state_q == ST_DRAW) begin
			case (op_q)
				MODE_OUTLINE: begin
					mem_req.we = border;
				end
				MODE_FILL: begin
					mem_req.we = 1'b1;
				end
				MODE_FILL_OUTLINE: begin
					mem_req.we    = 1'b1;
					mem_req.wdata = border ? draw_q : fill_q;
				end
				default: begin
					mem_req.we = 1'b0;
				end
			endcase
		end
	end

	tfre_frame_mem u_frame_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		load_clear  = 1'b0;
		load_rect   = 1'b0;
		load_read   = 1'b0;
		finish      = 1'b0;
		finish_read = 1'b0;
		fin_status  = STATUS_DONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_CLEAR: begin
							if (frame_empty) begin
								finish = 1'b1;
							end else begin
								load_clear = 1'b1;
								state_d    = ST_DRAW;
							end
						end
						MODE_OUTLINE, MODE_FILL, MODE_FILL_OUTLINE: begin
							if (rect_bad) begin
								finish     = 1'b1;
								fin_status = STATUS_REJECTED;
							end else begin
								load_rect = 1'b1;
								state_d   = ST_DRAW;
							end
						end
						MODE_READ: begin
							if (read_bad) begin
								finish     = 1'b1;
								fin_status = STATUS_REJECTED;
							end else begin
								load_read = 1'b1;
								state_d   = ST_READ;
							end
						end
						default: begin
							finish     = 1'b1;
							fin_status = STATUS_REJECTED;
						end
					endcase
				end
			end
			ST_DRAW: begin
				if (last_cell) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				finish_read = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[6:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_clear) begin
			op_q       <= MODE_FILL;
			row_base_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			wm1_q      <= COL_W'(fw_eff - 8'd1);
			hm1_q      <= ROW_W'(fh_eff - 7'd1);
			draw_q     <= draw_byte;
			fill_q     <= fill_byte;
		end else if (load_rect || load_read) begin
			op_q       <= mode;
			row_base_q <= start_addr;
			col_q      <= '0;
			row_q      <= '0;
			wm1_q      <= COL_W'(rect_width - 8'd1);
			hm1_q      <= ROW_W'(rect_height - 7'd1);
			draw_q     <= draw_byte;
			fill_q     <= fill_byte;
		end else if (state_q == ST_DRAW) begin
			if (col_q == wm1_q) begin
				col_q      <= '0;
				row_q      <= row_q + ROW_W'(1);
				row_base_q <= row_base_q + AW'(fw_eff);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			status_q    <= STATUS_DONE;
			read_byte_q <= 8'd0;
		end else begin
			done_q      <= finish || finish_read;
			status_q    <= fin_status;
			read_byte_q <= finish_read ? rd_data : 8'd0;
		end
	end

	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result given while a command is still in progress");

	a_walk_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> ((row_q <= hm1_q) && (col_q <= wm1_q)))
		else $error("cell walk has left the rectangle");

	a_write_only_drawing: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> (state_q == ST_DRAW))
		else $error("cell store written outside a drawing pass");

	a_read_byte_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (read_byte_q != 8'd0)) |-> ($past(state_q) == ST_RESP))
		else $error("nonzero read byte on a result that is not a cell read");

endmodule
